// File: rtl/cet_pkg.sv
// shared types and constants for the edge thinning unit
// no dependencies
package cet_pkg;

    typedef struct packed {
        logic [7:0] pixel;
        logic       flush;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] blurred;
        logic [7:0] magnitude;
        logic [1:0] direction;
        logic       edge_res;
        logic       last_of_frame;
    } pix_out_t;

    // one stream position of the pixel or blurred line
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } samp_t;

    // one stream position of the gradient line
    typedef struct packed {
        logic        valid;
        logic [7:0]  blurred;
        logic [10:0] mag;
        logic [1:0]  dir;
    } grad_t;

    // line memory word: values one and two rows back for each stage
    typedef struct packed {
        samp_t in2;
        samp_t in1;
        samp_t bl2;
        samp_t bl1;
        grad_t gr2;
        grad_t gr1;
    } line_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_BLUR  = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_GRAD  = 10'b0000010000,
        S_SQ    = 10'b0000100000,
        S_SUM   = 10'b0001000000,
        S_ROOT  = 10'b0010000000,
        S_STORE = 10'b0100000000,
        S_NMS   = 10'b1000000000
    } state_t;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_0   = 2'd0;
    localparam logic [1:0] DIR_45  = 2'd1;
    localparam logic [1:0] DIR_90  = 2'd2;
    localparam logic [1:0] DIR_135 = 2'd3;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    localparam logic [11:0] RECIP3       = 12'd2731;
    localparam int          RECIP3_SHIFT = 13;
    localparam logic [12:0] RECIP9       = 13'd7282;
    localparam int          RECIP9_SHIFT = 16;

    localparam logic [9:0] TAN_LO = 10'd106;
    localparam logic [9:0] TAN_HI = 10'd618;

    localparam logic [3:0] ROOT_STEPS = 4'd10;

endpackage

// File: rtl/cet_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module cet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/canny_edge_thinning_unit.sv
// top level of the edge thinning unit: blur, sobel gradient and suppression
// depends on cet_pkg and cet_ram
// each transaction steps through load, blur, divide, gradient, square, sum, the
// bit-pair square root, store and suppression, plus any wait for the result register
// to empty; an ignored flush leaves the block idle; the result for a pixel leaves with
// the transaction 3*width+3 positions later, registered by that transaction's last step
// all row history sits in one line memory of MAX_WIDTH words read then written back
// reset and any register write clear counters, windows and fill count; no clearing pass
module canny_edge_thinning_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cet_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cet_pkg::pix_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [11:0]       cfg_wdata
);
    import cet_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int NMAX = 4 * MAX_WIDTH;
    localparam int NW   = $clog2(NMAX + 1);

    state_t          state_reg;
    logic [10:0]     width_reg;
    logic [11:0]     height_reg;
    logic [AW-1:0]   col_reg, blc_reg, gdc_reg, nmc_reg, p_reg;
    logic [11:0]     row_reg, blr_reg, gdr_reg, nmr_reg;
    logic [NW-1:0]   n_reg;
    samp_t           in_elem_reg, b_new_reg;
    samp_t           in_win_reg [3][3];
    samp_t           bl_win_reg [3][3];
    grad_t           gr_win_reg [3][3];
    logic [11:0]     sum_reg;
    logic [4:0]      cnt_reg;
    logic signed [10:0] gx_reg, gy_reg;
    logic [20:0]     sqx_reg, sqy_reg;
    logic [1:0]      dir_reg;
    logic [21:0]     rem_reg, root_reg;
    logic [3:0]      step_reg;
    logic            out_valid_reg;
    pix_out_t        out_reg;

    logic [WW-1:0]   w_eff, wm1;
    logic [11:0]     h_eff, hm1;
    logic [NW-1:0]   thr1, thr2, thr3;
    line_t           rd, wr_word;
    logic            accept, ignore, ram_re, ram_we;

    function automatic logic [11+AW:0] advance(input logic [AW-1:0] c, input logic [11:0] r,
                                               input logic [WW-1:0] wl, input logic [11:0] hl);
        logic [AW-1:0] cn;
        logic [11:0]   rn;
        cn = c + 1'b1;
        rn = r;
        if (WW'(c) == wl)
        begin
            cn = '0;
            rn = (r == hl) ? 12'd0 : r + 12'd1;
        end
        return {rn, cn};
    endfunction

    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg == 12'd0) ? 12'd1 : height_reg;
        wm1   = w_eff - WW'(1);
        hm1   = h_eff - 12'd1;
        thr1  = NW'(w_eff);
        thr2  = NW'(32'(w_eff) * 2 + 1);
        thr3  = NW'(32'(w_eff) * 3 + 2);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign ignore   = in_data.flush && ((col_reg != '0) || (row_reg != 12'd0));
    assign ram_re   = accept && !ignore;
    assign ram_we   = (state_reg == S_STORE);

    cet_ram #(
        .WIDTH($bits(line_t)),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .clk  (clk),
        .we   (ram_we),
        .waddr(p_reg),
        .wdata(wr_word),
        .re   (ram_re),
        .raddr(p_reg),
        .rdata(rd)
    );

    // blur taps
    logic        bl_top, bl_bot, bl_lft, bl_rgt;
    logic [11:0] blur_sum;
    logic [2:0]  rw, cw;
    logic [4:0]  blur_cnt;
    logic [2:0]  rok, cok;

    always_comb
    begin
        bl_top = (blr_reg != 12'd0);
        bl_bot = (blr_reg != hm1);
        bl_lft = (blc_reg != '0);
        bl_rgt = (WW'(blc_reg) != wm1);
        rok = {bl_bot, 1'b1, bl_top};
        cok = {bl_rgt, 1'b1, bl_lft};
        blur_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rok[i] && cok[j])
                    blur_sum = blur_sum + (12'(in_win_reg[i][j].value)
                               << ((i == 1 ? 1 : 0) + (j == 1 ? 1 : 0)));
            end
        end
        rw = 3'd2 + 3'(bl_top) + 3'(bl_bot);
        cw = 3'd2 + 3'(bl_lft) + 3'(bl_rgt);
        blur_cnt = 5'(rw) * 5'(cw);
    end

    // divide by the weight count
    logic [7:0]  blur_q;
    logic [23:0] prod3;
    logic [24:0] prod9;
    logic [10:0] div3_in;
    samp_t       b_new, bl_mid;

    always_comb
    begin
        div3_in = (cnt_reg == 5'd12) ? 11'(sum_reg >> 2) : 11'(sum_reg >> 1);
        prod3   = 24'(div3_in) * 24'(RECIP3);
        prod9   = 25'(sum_reg) * 25'(RECIP9);
        case (cnt_reg)
            5'd16:   blur_q = 8'(sum_reg >> 4);
            5'd12:   blur_q = 8'(prod3 >> RECIP3_SHIFT);
            5'd9:    blur_q = 8'(prod9 >> RECIP9_SHIFT);
            5'd8:    blur_q = 8'(sum_reg >> 3);
            5'd6:    blur_q = 8'(prod3 >> RECIP3_SHIFT);
            default: blur_q = 8'(sum_reg >> 2);
        endcase
        b_new.valid = in_win_reg[1][1].valid;
        b_new.value = in_win_reg[1][1].valid ? blur_q : 8'd0;
        bl_mid       = rd.bl1;
        bl_mid.valid = rd.bl1.valid && (n_reg > thr2);
    end

    // sobel
    logic        gd_top, gd_bot, gd_lft, gd_rgt;
    logic signed [11:0] tb [3][3];
    logic signed [11:0] gx_c, gy_c;

    always_comb
    begin
        gd_top = (gdr_reg != 12'd0);
        gd_bot = (gdr_reg != hm1);
        gd_lft = (gdc_reg != '0);
        gd_rgt = (WW'(gdc_reg) != wm1);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                tb[i][j] = ((i == 0 ? gd_top : (i == 2 ? gd_bot : 1'b1))
                            && (j == 0 ? gd_lft : (j == 2 ? gd_rgt : 1'b1)))
                           ? $signed({4'b0, bl_win_reg[i][j].value}) : 12'sd0;
            end
        end
        gx_c = (tb[0][2] + 12'sd2 * tb[1][2] + tb[2][2])
               - (tb[0][0] + 12'sd2 * tb[1][0] + tb[2][0]);
        gy_c = (tb[0][0] + 12'sd2 * tb[0][1] + tb[0][2])
               - (tb[2][0] + 12'sd2 * tb[2][1] + tb[2][2]);
    end

    // squares and direction
    logic signed [21:0] gx_w, gy_w;
    logic [9:0]  ax, ay;
    logic [19:0] ay_s, ax_lo, ax_hi;
    logic [1:0]  dir_c;

    always_comb
    begin
        gx_w  = 22'(gx_reg);
        gy_w  = 22'(gy_reg);
        ax    = gx_reg[10] ? 10'(-gx_reg) : 10'(gx_reg);
        ay    = gy_reg[10] ? 10'(-gy_reg) : 10'(gy_reg);
        ay_s  = {2'b0, ay, 8'h00};
        ax_lo = 20'(ax) * 20'(TAN_LO);
        ax_hi = 20'(ax) * 20'(TAN_HI);
        if (ay_s <= ax_lo)
            dir_c = DIR_0;
        else if (ay_s > ax_hi)
            dir_c = DIR_90;
        else if ((gx_reg > 0) == (gy_reg > 0))
            dir_c = DIR_45;
        else
            dir_c = DIR_135;
    end

    // square root step
    logic [21:0] root_bit, trial;

    assign root_bit = 22'(1) << {step_reg, 1'b0};
    assign trial    = root_reg + root_bit;

    // gradient word and line write-back
    grad_t g_new, gr_mid;
    samp_t in_mid;

    always_comb
    begin
        g_new.valid   = bl_win_reg[1][1].valid;
        g_new.blurred = bl_win_reg[1][1].valid ? bl_win_reg[1][1].value : 8'd0;
        g_new.mag     = bl_win_reg[1][1].valid ? root_reg[10:0] : 11'd0;
        g_new.dir     = bl_win_reg[1][1].valid ? dir_reg : DIR_0;
        gr_mid        = rd.gr1;
        gr_mid.valid  = rd.gr1.valid && (n_reg > thr3);
        in_mid        = rd.in1;
        in_mid.valid  = rd.in1.valid && (n_reg > thr1);
        wr_word.in2   = rd.in1;
        wr_word.in1   = in_elem_reg;
        wr_word.bl2   = rd.bl1;
        wr_word.bl1   = b_new_reg;
        wr_word.gr2   = rd.gr1;
        wr_word.gr1   = g_new;
    end

    // suppression
    logic        nm_top, nm_bot, nm_lft, nm_rgt;
    logic        pres1, pres2, edge_c;
    logic [10:0] nb1, nb2, cmag;
    logic        slot_free, out_load;

    always_comb
    begin
        nm_top = (nmr_reg != 12'd0);
        nm_bot = (nmr_reg != hm1);
        nm_lft = (nmc_reg != '0);
        nm_rgt = (WW'(nmc_reg) != wm1);
        cmag   = gr_win_reg[1][1].mag;
        case (gr_win_reg[1][1].dir)
            DIR_0:
            begin
                nb1 = gr_win_reg[1][2].mag; pres1 = nm_rgt;
                nb2 = gr_win_reg[1][0].mag; pres2 = nm_lft;
            end
            DIR_45:
            begin
                nb1 = gr_win_reg[0][2].mag; pres1 = nm_top && nm_rgt;
                nb2 = gr_win_reg[2][0].mag; pres2 = nm_bot && nm_lft;
            end
            DIR_90:
            begin
                nb1 = gr_win_reg[0][1].mag; pres1 = nm_top;
                nb2 = gr_win_reg[2][1].mag; pres2 = nm_bot;
            end
            DIR_135:
            begin
                nb1 = gr_win_reg[0][0].mag; pres1 = nm_top && nm_lft;
                nb2 = gr_win_reg[2][2].mag; pres2 = nm_bot && nm_rgt;
            end
            default:
            begin
                nb1 = '0; pres1 = 1'b0;
                nb2 = '0; pres2 = 1'b0;
            end
        endcase
        edge_c    = !(pres1 && (nb1 > cmag)) && !(pres2 && (nb2 > cmag));
        slot_free = !out_valid_reg || out_ready;
        out_load  = !cfg_we && (state_reg == S_NMS) && gr_win_reg[1][1].valid && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            blc_reg       <= '0;
            blr_reg       <= '0;
            gdc_reg       <= '0;
            gdr_reg       <= '0;
            nmc_reg       <= '0;
            nmr_reg       <= '0;
            p_reg         <= '0;
            n_reg         <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    in_win_reg[i][j] <= '0;
                    bl_win_reg[i][j] <= '0;
                    gr_win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_IMAGE_WIDTH)
                    width_reg <= cfg_wdata[10:0];
                else
                    height_reg <= cfg_wdata;
                state_reg <= S_IDLE;
                col_reg   <= '0;
                row_reg   <= '0;
                blc_reg   <= '0;
                blr_reg   <= '0;
                gdc_reg   <= '0;
                gdr_reg   <= '0;
                nmc_reg   <= '0;
                nmr_reg   <= '0;
                p_reg     <= '0;
                n_reg     <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        in_win_reg[i][j] <= '0;
                        bl_win_reg[i][j] <= '0;
                        gr_win_reg[i][j] <= '0;
                    end
                end
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (accept && !ignore)
                        begin
                            in_elem_reg.valid <= !in_data.flush;
                            in_elem_reg.value <= in_data.flush ? 8'd0 : in_data.pixel;
                            if (!in_data.flush)
                                {row_reg, col_reg} <= advance(col_reg, row_reg, wm1, hm1);
                            if (32'(n_reg) < NMAX)
                                n_reg <= n_reg + NW'(1);
                            state_reg <= S_LOAD;
                        end
                    end
                    S_LOAD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            in_win_reg[i][0] <= in_win_reg[i][1];
                            in_win_reg[i][1] <= in_win_reg[i][2];
                        end
                        in_win_reg[0][2] <= rd.in2;
                        in_win_reg[1][2] <= in_mid;
                        in_win_reg[2][2] <= in_elem_reg;
                        state_reg <= S_BLUR;
                    end
                    S_BLUR:
                    begin
                        sum_reg   <= blur_sum;
                        cnt_reg   <= blur_cnt;
                        state_reg <= S_DIV;
                    end
                    S_DIV:
                    begin
                        b_new_reg <= b_new;
                        for (int i = 0; i < 3; i++)
                        begin
                            bl_win_reg[i][0] <= bl_win_reg[i][1];
                            bl_win_reg[i][1] <= bl_win_reg[i][2];
                        end
                        bl_win_reg[0][2] <= rd.bl2;
                        bl_win_reg[1][2] <= bl_mid;
                        bl_win_reg[2][2] <= b_new;
                        if (in_win_reg[1][1].valid)
                            {blr_reg, blc_reg} <= advance(blc_reg, blr_reg, wm1, hm1);
                        state_reg <= S_GRAD;
                    end
                    S_GRAD:
                    begin
                        gx_reg    <= 11'(gx_c);
                        gy_reg    <= 11'(gy_c);
                        state_reg <= S_SQ;
                    end
                    S_SQ:
                    begin
                        sqx_reg   <= 21'(gx_w * gx_w);
                        sqy_reg   <= 21'(gy_w * gy_w);
                        dir_reg   <= dir_c;
                        state_reg <= S_SUM;
                    end
                    S_SUM:
                    begin
                        rem_reg   <= 22'(sqx_reg) + 22'(sqy_reg);
                        root_reg  <= '0;
                        step_reg  <= ROOT_STEPS;
                        state_reg <= S_ROOT;
                    end
                    S_ROOT:
                    begin
                        if (rem_reg >= trial)
                        begin
                            rem_reg  <= rem_reg - trial;
                            root_reg <= (root_reg >> 1) + root_bit;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        if (step_reg == 4'd0)
                            state_reg <= S_STORE;
                        else
                            step_reg <= step_reg - 4'd1;
                    end
                    S_STORE:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            gr_win_reg[i][0] <= gr_win_reg[i][1];
                            gr_win_reg[i][1] <= gr_win_reg[i][2];
                        end
                        gr_win_reg[0][2] <= rd.gr2;
                        gr_win_reg[1][2] <= gr_mid;
                        gr_win_reg[2][2] <= g_new;
                        if (bl_win_reg[1][1].valid)
                            {gdr_reg, gdc_reg} <= advance(gdc_reg, gdr_reg, wm1, hm1);
                        p_reg     <= (WW'(p_reg) == wm1) ? '0 : p_reg + 1'b1;
                        state_reg <= S_NMS;
                    end
                    S_NMS:
                    begin
                        if (!gr_win_reg[1][1].valid)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (slot_free)
                        begin
                            out_reg.blurred        <= gr_win_reg[1][1].blurred;
                            out_reg.magnitude      <= (cmag > 11'd255) ? 8'd255 : cmag[7:0];
                            out_reg.direction      <= gr_win_reg[1][1].dir;
                            out_reg.edge_res       <= edge_c;
                            out_reg.last_of_frame  <= (nmr_reg == hm1) && (WW'(nmc_reg) == wm1);
                            {nmr_reg, nmc_reg}     <= advance(nmc_reg, nmr_reg, wm1, hm1);
                            state_reg              <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ignore && !cfg_we) |=> (state_reg == S_LOAD))
        else $error("accepted transaction did not start processing");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= NMAX)
        else $error("fill count out of range");

    a_out_from_nms: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_NMS))
        else $error("result loaded outside suppression step");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < w_eff)
        else $error("column counter beyond width");

endmodule

// File: test/cet_checker.sv
// predictor and scoreboard for the edge thinning unit
// watches the config port and both channels; depends on cet_pkg
module cet_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  cet_pkg::pix_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  cet_pkg::pix_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [11:0]       cfg_wdata,
    input  logic              end_of_test,
    output int                errors,
    output int                outstanding
);
    import cet_pkg::*;

    localparam int MAXW = 1024;
    localparam int HIST = 4 * MAXW + 8;

    int unsigned px_hist [HIST];
    int unsigned blur_hist [HIST];
    int unsigned mag_hist [HIST];
    logic [1:0]  dir_hist [HIST];
    bit          pos_ok [HIST];
    int          pos_r [HIST];
    int          pos_c [HIST];
    int          col_n;
    int          row_n;
    int          head_slot;
    logic [10:0] width_reg;
    logic [11:0] height_reg;

    pix_out_t pending_results[$];
    int       results_seen;

    initial errors = 0;
    assign outstanding = pending_results.size();

    function automatic int eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAXW)
            return MAXW;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic int back(int k);
        return (head_slot + HIST - k) % HIST;
    endfunction

    function automatic bit in_img(int r, int c, int w, int h);
        return r >= 0 && r < h && c >= 0 && c < w;
    endfunction

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned r;
        r = $rtoi($sqrt(real'(v)));
        while (r * r > v)
            r--;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    task automatic clear_stream();
        for (int i = 0; i < HIST; i++)
        begin
            px_hist[i] = 0;
            blur_hist[i] = 0;
            mag_hist[i] = 0;
            dir_hist[i] = DIR_0;
            pos_ok[i] = 0;
            pos_r[i] = 0;
            pos_c[i] = 0;
        end
        col_n = 0;
        row_n = 0;
        head_slot = 0;
    endtask

    task automatic blur_at(int w, int h);
        int k;
        int s;
        int sum;
        int cnt;
        int wt;
        k = w + 1;
        s = back(k);
        sum = 0;
        cnt = 0;
        if (!pos_ok[s])
        begin
            blur_hist[s] = 0;
            return;
        end
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (in_img(pos_r[s] + dr, pos_c[s] + dc, w, h))
                begin
                    wt = (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1);
                    sum += int'(px_hist[back(k - (dr * w + dc))]) * wt;
                    cnt += wt;
                end
        blur_hist[s] = sum / cnt;
    endtask

    task automatic gradient_at(int w, int h);
        int k;
        int s;
        int gx;
        int gy;
        int ax;
        int ay;
        int b;
        k = 2 * (w + 1);
        s = back(k);
        gx = 0;
        gy = 0;
        if (!pos_ok[s])
        begin
            mag_hist[s] = 0;
            dir_hist[s] = DIR_0;
            return;
        end
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (in_img(pos_r[s] + dr, pos_c[s] + dc, w, h))
                begin
                    b = int'(blur_hist[back(k - (dr * w + dc))]);
                    gx += b * dc * (dr == 0 ? 2 : 1);
                    gy -= b * dr * (dc == 0 ? 2 : 1);
                end
        mag_hist[s] = int_sqrt(gx * gx + gy * gy);
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (256 * ay <= 106 * ax)
            dir_hist[s] = DIR_0;
        else if (256 * ay > 618 * ax)
            dir_hist[s] = DIR_90;
        else if ((gx > 0) == (gy > 0))
            dir_hist[s] = DIR_45;
        else
            dir_hist[s] = DIR_135;
    endtask

    task automatic suppress_at(int w, int h, output bit got, output pix_out_t res);
        int k;
        int s;
        int dr;
        int dc;
        bit keep;
        k = 3 * (w + 1);
        s = back(k);
        got = 0;
        res = '0;
        keep = 1;
        if (!pos_ok[s])
            return;
        for (int i = 0; i < 2; i++)
        begin
            case (dir_hist[s])
                DIR_0:   begin dr = 0;               dc = (i == 0) ? 1 : -1;  end
                DIR_45:  begin dr = (i == 0) ? -1 : 1; dc = (i == 0) ? 1 : -1; end
                DIR_90:  begin dr = (i == 0) ? -1 : 1; dc = 0;                 end
                default: begin dr = (i == 0) ? -1 : 1; dc = (i == 0) ? -1 : 1; end
            endcase
            if (in_img(pos_r[s] + dr, pos_c[s] + dc, w, h))
                if (mag_hist[back(k - (dr * w + dc))] > mag_hist[s])
                    keep = 0;
        end
        got = 1;
        res.blurred = blur_hist[s][7:0];
        res.magnitude = (mag_hist[s] > 255) ? 8'd255 : mag_hist[s][7:0];
        res.direction = dir_hist[s];
        res.edge_res = keep;
        res.last_of_frame = (pos_r[s] == h - 1 && pos_c[s] == w - 1);
    endtask

    task automatic advance_stream(pix_in_t item);
        int w;
        int h;
        bit got;
        pix_out_t res;
        w = eff_width();
        h = eff_height();
        if (item.flush)
        begin
            if (col_n != 0 || row_n != 0)
                return;
            head_slot = (head_slot + 1) % HIST;
            pos_ok[head_slot] = 0;
            px_hist[head_slot] = 0;
        end
        else
        begin
            head_slot = (head_slot + 1) % HIST;
            pos_ok[head_slot] = 1;
            px_hist[head_slot] = item.pixel;
            pos_r[head_slot] = row_n;
            pos_c[head_slot] = col_n;
            col_n++;
            if (col_n >= w)
            begin
                col_n = 0;
                row_n++;
                if (row_n >= h)
                    row_n = 0;
            end
        end
        blur_at(w, h);
        gradient_at(w, h);
        suppress_at(w, h, got, res);
        if (got)
            pending_results.push_back(res);
    endtask

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic compare_result(pix_out_t got);
        pix_out_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected transaction, blurred", got.blurred, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.blurred !== want.blurred)
            report("blurred", got.blurred, want.blurred);
        if (got.magnitude !== want.magnitude)
            report("magnitude", got.magnitude, want.magnitude);
        if (got.direction !== want.direction)
            report("direction", got.direction, want.direction);
        if (got.edge_res !== want.edge_res)
            report("edge_res", got.edge_res, want.edge_res);
        if (got.last_of_frame !== want.last_of_frame)
            report("last_of_frame", got.last_of_frame, want.last_of_frame);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            results_seen = 0;
            pending_results.delete();
            clear_stream();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_IMAGE_WIDTH)
                    width_reg = cfg_wdata[10:0];
                else
                    height_reg = cfg_wdata;
                clear_stream();
            end
            if (in_valid && in_ready)
                advance_stream(in_data);
            if (out_valid && out_ready)
            begin
                compare_result(out_data);
                results_seen++;
            end
        end
    end

    always @(posedge end_of_test)
    begin
        if (pending_results.size() != 0)
            report("results never delivered, count", pending_results.size(), 0);
    end

endmodule

// File: test/tb_canny_edge_thinning_unit.sv
// stimulus and verdict for the edge thinning unit
// depends on cet_pkg, canny_edge_thinning_unit and cet_checker
module tb_canny_edge_thinning_unit;
    import cet_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_ready;
    pix_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 0;
    pix_out_t out_data;
    logic     cfg_we = 0;
    logic     cfg_addr = REG_IMAGE_WIDTH;
    logic [11:0] cfg_wdata = '0;
    logic     end_of_test = 0;
    int       errors;
    int       outstanding;

    int  burst_left = 0;
    bit  squeeze = 0;
    int  idle_cycles = 0;
    int  pixels_sent = 0;
    int  frames_sent = 0;
    int  cur_w;
    int  cur_h;

    always #1 clk = ~clk;

    canny_edge_thinning_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    cet_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .end_of_test(end_of_test), .errors(errors), .outstanding(outstanding)
    );

    // receiver stall pattern, plus one long hold-off when asked
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze && !held)
            begin
                out_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                case (mode)
                    0:       out_ready <= 1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_canny_edge_thinning_unit: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] pix, logic fl);
        in_valid <= 1;
        in_data <= '{pixel: pix, flush: fl};
        do
            @(posedge clk);
        while (!in_ready);
        if (!fl)
            pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic set_size(int w, int h);
        cfg_we <= 1;
        cfg_addr <= REG_IMAGE_WIDTH;
        cfg_wdata <= 12'(w);
        @(posedge clk);
        cfg_addr <= REG_IMAGE_HEIGHT;
        cfg_wdata <= 12'(h);
        @(posedge clk);
        cfg_we <= 0;
        cur_w = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
        cur_h = (h == 0) ? 1 : h;
    endtask

    // push the last frame out with bubbles, then wait until the block is quiet
    task automatic drain();
        repeat (3 * cur_w + 3)
            send_item(8'd0, 1'b1);
        in_valid <= 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [7:0] frame_pixel(int style, int r, int c);
        case (style)
            0:       return 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2:       return 8'(c * 37 + r * 11);
            default: return (c > cur_w / 2) ? 8'd230 : 8'd15;
        endcase
    endfunction

    task automatic send_frame(int noise);
        int style;
        style = $urandom_range(0, 3);
        for (int r = 0; r < cur_h; r++)
            for (int c = 0; c < cur_w; c++)
            begin
                if ((r != 0 || c != 0) && $urandom_range(0, 99) < noise)
                    send_item(8'($urandom), 1'b1);
                send_item(frame_pixel(style, r, c), 1'b0);
            end
        frames_sent++;
    endtask

    task automatic random_phase(int w, int h, int frames);
        set_size(w, h);
        for (int f = 0; f < frames; f++)
        begin
            send_frame(5);
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b1);
        end
        drain();
    endtask

    initial
    begin
        logic [7:0] edge_rows [12];
        edge_rows = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                      8'd255, 8'd255, 8'd255, 8'd255};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, flush inside a frame, back-to-back frames, flat frame
        set_size(4, 3);
        for (int i = 0; i < 12; i++)
        begin
            send_item(edge_rows[i], 1'b0);
            if (i == 5)
                send_item(8'hAA, 1'b1);
        end
        for (int i = 0; i < 12; i++)
            send_item(8'd128, 1'b0);
        frames_sent += 2;
        drain();

        random_phase(1, 1, 3);
        random_phase(0, 0, 2);
        random_phase(2, 2, 3);
        random_phase(3, 5, 2);
        random_phase(6, 4, 2);
        random_phase(9, 3, 2);
        squeeze = 1;
        random_phase(5, 7, 2);
        random_phase(8, 8, 2);
        random_phase(13, 6, 1);

        end_of_test <= 1;
        @(posedge clk);
        @(posedge clk);
        $display("covered %0d pixels in %0d frames, sizes from 1x1 (and zero) up to 13x6,",
                 pixels_sent, frames_sent);
        $display("with in-frame and between-frame flushes and a long output hold-off");
        if (errors == 0)
            $display("tb_canny_edge_thinning_unit: PASS");
        else
            $display("tb_canny_edge_thinning_unit: FAIL");
        $finish;
    end

endmodule
